/* hdl/dnw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dnw_pkg
// Shared constants, types and helpers for the DNS name to wire form block.
// ----------------------------------------------------------------------------
package dnw_pkg;

    localparam int unsigned MAX_LABEL = 62;
    localparam int unsigned CNT_W     = 6;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [7:0]       t_byte;

    localparam t_byte CH_NUL     = 8'h00;
    localparam t_byte CH_DOT     = 8'h2E;
    localparam t_byte CH_UPPER_A = 8'h41;
    localparam t_byte CH_UPPER_Z = 8'h5A;
    localparam t_byte CH_LOWER_A = 8'h61;

    localparam t_cnt CNT_MAX = t_cnt'(MAX_LABEL);

    typedef struct packed {
        logic store_char;
        logic load_len;
        logic rd_issue;
        logic load_byte;
        logic load_fin;
        logic clear_label;
    } t_dnw_cmd;

    typedef struct packed {
        logic in_is_nul;
        logic in_is_dot;
        logic count_zero;
        logic idx_last;
        logic out_free;
    } t_dnw_sts;

    function automatic t_byte to_lower(input t_byte c);
        t_byte r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c - CH_UPPER_A + CH_LOWER_A;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/dnw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dnw_datapath
// Label buffer, label length and truncation flag, read index and output
// register for the DNS name to wire form block.
// ----------------------------------------------------------------------------
module dnw_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_in_char,
    input  wire logic              i_out_stall,
    input  wire dnw_pkg::t_dnw_cmd i_cmd,
    output dnw_pkg::t_dnw_sts      o_sts,
    output logic                   o_out_valid,
    output logic [7:0]             o_wire_byte,
    output logic                   o_last,
    output logic                   o_overlong
);
    import dnw_pkg::*;

    t_byte r_mem [0:MAX_LABEL-1];
    t_byte r_rd_data;

    t_cnt  r_count, n_count;
    t_cnt  r_idx,   n_idx;
    logic  r_trunc, n_trunc;

    logic  r_out_valid, n_out_valid;
    t_byte r_wire_byte, n_wire_byte;
    logic  r_last,      n_last;
    logic  r_overlong,  n_overlong;

    logic  room;

    assign room = (r_count < CNT_MAX);

    always_comb begin
        n_count = r_count;
        n_trunc = r_trunc;
        n_idx   = r_idx;
        if (i_cmd.store_char) begin
            if (room) begin
                n_count = r_count + t_cnt'(1);
            end else begin
                n_trunc = 1'b1;
            end
        end
        if (i_cmd.load_len) begin
            n_idx = '0;
        end
        if (i_cmd.load_byte) begin
            n_idx = r_idx + t_cnt'(1);
        end
        if (i_cmd.clear_label) begin
            n_count = '0;
            n_trunc = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_wire_byte = r_wire_byte;
        n_last      = r_last;
        n_overlong  = r_overlong;
        if (i_cmd.load_len) begin
            n_out_valid = 1'b1;
            n_wire_byte = {2'b00, r_count};
            n_last      = 1'b0;
            n_overlong  = r_trunc;
        end else if (i_cmd.load_byte) begin
            n_out_valid = 1'b1;
            n_wire_byte = r_rd_data;
            n_last      = 1'b0;
            n_overlong  = 1'b0;
        end else if (i_cmd.load_fin) begin
            n_out_valid = 1'b1;
            n_wire_byte = CH_NUL;
            n_last      = 1'b1;
            n_overlong  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_char && room) begin
            r_mem[r_count] <= to_lower(i_in_char);
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_trunc     <= n_trunc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wire_byte <= n_wire_byte;
        r_last      <= n_last;
        r_overlong  <= n_overlong;
    end

    assign o_sts.in_is_nul  = (i_in_char == CH_NUL);
    assign o_sts.in_is_dot  = (i_in_char == CH_DOT);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.idx_last   = (r_idx == r_count - t_cnt'(1));
    assign o_sts.out_free   = ~r_out_valid | ~i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_wire_byte = r_wire_byte;
    assign o_last      = r_last;
    assign o_overlong  = r_overlong;

endmodule
`default_nettype wire

/* hdl/dnw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dnw_ctrl
// Sequencer: accepts characters, then walks the length byte, the buffered
// label bytes and the final zero out through the output register.
// ----------------------------------------------------------------------------
module dnw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire dnw_pkg::t_dnw_sts i_sts,
    output dnw_pkg::t_dnw_cmd      o_cmd
);
    import dnw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_end,   n_end;

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_is_nul) begin
                        n_end   = 1'b1;
                        n_state = i_sts.count_zero ? ST_FIN : ST_LEN;
                    end else if (i_sts.in_is_dot) begin
                        n_end   = 1'b0;
                        n_state = ST_LEN;
                    end else begin
                        o_cmd.store_char = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_len = 1'b1;
                    if (i_sts.count_zero) begin
                        o_cmd.clear_label = 1'b1;
                        n_state = r_end ? ST_FIN : ST_IDLE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_WR;
            end
            ST_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clear_label = 1'b1;
                        n_state = r_end ? ST_FIN : ST_IDLE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_fin    = 1'b1;
                    o_cmd.clear_label = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* hdl/dns_name_to_wire_format.sv */
// Timing: a label character is only stored; a dot or the zero moves the
// sequencer on, which loads the first wire byte into the output register
// once it is free. Throughput: one character in per cycle while idle; each
// label byte out takes a buffer read state, then an output load state, set by
// the single read port; a length byte or the final zero takes only the load.
// Reset: synchronous, active low; clears sequencer, label state and output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_to_wire_format
// Converts a dotted domain name, one character per request and ended by a
// zero, into DNS wire form with lower-cased labels.
// ----------------------------------------------------------------------------
module dns_name_to_wire_format (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_char,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_wire_byte,
    output logic            o_last,
    output logic            o_overlong
);
    import dnw_pkg::*;

    t_dnw_cmd cmd;
    t_dnw_sts sts;

    dnw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dnw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_char   (i_in_char),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_wire_byte (o_wire_byte),
        .o_last      (o_last),
        .o_overlong  (o_overlong)
    );

endmodule
`default_nettype wire
